FILE: rtl/binary_blob_feature_extractor_macros.svh
// Assertion helpers shared by the blob feature RTL.
// Each macro expects clk and rst_n in scope.
`ifndef BINARY_BLOB_FEATURE_EXTRACTOR_MACROS_SVH
`define BINARY_BLOB_FEATURE_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define BBFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bbfe_pkg.sv
`default_nettype none

package bbfe_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W = 11;
    localparam int THR_W   = 8;
    localparam int BOX_W   = 10;
    localparam int COUNT_W = 21;
    localparam int SUM_W   = 30;
    localparam int QUAD_W  = 20;
    localparam int EULER_W = 22;

    localparam logic [THR_W-1:0]   THR_RESET   = 8'd200;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd1024;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_WIDTH     = 1'b1
    } cfg_reg_t;

    // line buffer access request: one write and one read address
    typedef struct packed {
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        logic             wr_bit;
        logic [COL_W-1:0] rd_addr;
    } lb_req_t;

endpackage

`default_nettype wire

FILE: rtl/bbfe_if.sv
`default_nettype none

interface bbfe_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_end;

    modport source (output valid, pixel, frame_end, input ready);
    modport sink   (input valid, pixel, frame_end, output ready);
endinterface

interface bbfe_feature_if;
    logic        valid;
    logic        ready;
    logic [9:0]  top_row;
    logic [9:0]  left_col;
    logic [9:0]  bottom_row;
    logic [9:0]  right_col;
    logic [20:0] fg_count;
    logic [29:0] row_total;
    logic [29:0] col_total;
    logic signed [21:0] euler_number;
    logic        empty_frame;

    modport source (output valid, top_row, left_col, bottom_row, right_col, fg_count,
                    row_total, col_total, euler_number, empty_frame, input ready);
    modport sink   (input valid, top_row, left_col, bottom_row, right_col, fg_count,
                    row_total, col_total, euler_number, empty_frame, output ready);
endinterface

`default_nettype wire

FILE: rtl/bbfe_line_buf.sv
`default_nettype none

// One-row bit memory, read every cycle, write-first on an address match.
module bbfe_line_buf (
    input  wire logic             clk,
    input  wire bbfe_pkg::lb_req_t req,
    output logic                  up_bit
);

    logic mem [bbfe_pkg::MAX_WIDTH];
    logic rd_bit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en && (req.wr_addr == req.rd_addr))
        begin
            rd_bit_reg <= req.wr_bit;
        end
        else
        begin
            rd_bit_reg <= mem[req.rd_addr];
        end
    end

    assign up_bit = rd_bit_reg;

endmodule

`default_nettype wire

FILE: rtl/binary_blob_feature_extractor.sv
// channel   | dir | handshake     | payload
// ----------+-----+---------------+-----------------------------------------------
// pix_in    | in  | valid/ready   | pixel[7:0], frame_end
// feat_out  | out | valid/ready   | box (4 x 10b), fg_count, row/col_total, euler, empty
// apb cfg   | in  | psel/penable  | 0x0 fg_threshold, 0x4 image_width; pready tied high
//
// One pixel per clock while not stalled: each item reads its upper neighbor (prefetched by
// col_pos_next at the previous accept), updates the totals and writes its own bit.
// A frame_end item goes to a staging register, then to the output register once the
// output register is free; the result is offered on feat_out from the output register.
// Input stalls only while staging is full and the output register is held.
// rst_n is asynchronous, active low; the line buffer is not cleared, row 0 masks it.
`default_nettype none

`include "binary_blob_feature_extractor_macros.svh"

module binary_blob_feature_extractor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    bbfe_pixel_if.sink       pix_in,
    bbfe_feature_if.source   feat_out
);

    localparam int COL_W   = bbfe_pkg::COL_W;
    localparam int ROW_W   = bbfe_pkg::ROW_W;
    localparam int WIDTH_W = bbfe_pkg::WIDTH_W;
    localparam int THR_W   = bbfe_pkg::THR_W;
    localparam int BOX_W   = bbfe_pkg::BOX_W;
    localparam int COUNT_W = bbfe_pkg::COUNT_W;
    localparam int SUM_W   = bbfe_pkg::SUM_W;
    localparam int QUAD_W  = bbfe_pkg::QUAD_W;
    localparam int EULER_W = bbfe_pkg::EULER_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0]   thr_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic               cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= bbfe_pkg::THR_RESET;
            width_reg <= bbfe_pkg::WIDTH_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (bbfe_pkg::cfg_reg_t'(paddr[2]))
                bbfe_pkg::REG_THRESHOLD: thr_reg   <= pwdata[THR_W-1:0];
                bbfe_pkg::REG_WIDTH:     width_reg <= pwdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (bbfe_pkg::cfg_reg_t'(paddr[2]))
            bbfe_pkg::REG_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, thr_reg};
            bbfe_pkg::REG_WIDTH:     prdata = {{(32-WIDTH_W){1'b0}}, width_reg};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Scan position and per-frame accumulators
    // ------------------------------------------------------------------
    logic [COL_W-1:0]   col_pos_reg,   col_pos_next;
    logic [ROW_W-1:0]   row_pos_reg,   row_pos_next;
    logic               left_bit_reg,  left_bit_next;
    logic               upleft_bit_reg, upleft_bit_next;
    logic [ROW_W-1:0]   min_row_reg,   min_row_next;
    logic [COL_W-1:0]   min_col_reg,   min_col_next;
    logic [ROW_W-1:0]   max_row_reg,   max_row_next;
    logic [COL_W-1:0]   max_col_reg,   max_col_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [SUM_W-1:0]   row_sum_reg,   row_sum_next;
    logic [SUM_W-1:0]   col_sum_reg,   col_sum_next;
    logic [QUAD_W-1:0]  convex_reg,    convex_next;
    logic [QUAD_W-1:0]  concave_reg,   concave_next;

    // staging register: raw frame totals of the last frame
    logic               s_valid_reg,   s_valid_next;
    logic [ROW_W-1:0]   s_min_row_reg;
    logic [COL_W-1:0]   s_min_col_reg;
    logic [ROW_W-1:0]   s_max_row_reg;
    logic [COL_W-1:0]   s_max_col_reg;
    logic [COUNT_W-1:0] s_count_reg;
    logic [SUM_W-1:0]   s_row_sum_reg;
    logic [SUM_W-1:0]   s_col_sum_reg;
    logic [QUAD_W-1:0]  s_convex_reg;
    logic [QUAD_W-1:0]  s_concave_reg;

    // output register
    logic               o_valid_reg,   o_valid_next;
    logic [BOX_W-1:0]   o_top_reg, o_left_reg, o_bottom_reg, o_right_reg;
    logic [COUNT_W-1:0] o_count_reg;
    logic [SUM_W-1:0]   o_row_sum_reg, o_col_sum_reg;
    logic [EULER_W-1:0] o_euler_reg;
    logic               o_empty_reg;

    logic               acc;
    logic               last;
    logic               cur;
    logic               up_raw;
    logic               up;
    logic               lf;
    logic               ul;
    logic               convex_hit;
    logic               concave_hit;
    logic [WIDTH_W-1:0] width_eff;
    logic               row_wrap;
    logic [COL_W-1:0]   col_step;
    logic               o_free;
    logic               s_move;
    logic [COUNT_W:0]   count_sum;
    logic [SUM_W:0]     row_sum_sum;
    logic [SUM_W:0]     col_sum_sum;
    logic [QUAD_W:0]    convex_sum;
    logic [QUAD_W:0]    concave_sum;
    logic               s_empty;
    bbfe_pkg::lb_req_t  lb_req;

    // input stalls only while staging is full and cannot move on this cycle
    assign pix_in.ready = !s_valid_reg || o_free;
    assign acc          = pix_in.valid && pix_in.ready;
    assign last         = pix_in.frame_end;

    // width 0 acts as 1, widths beyond the buffer clamp to it
    always_comb
    begin
        if (width_reg == '0)
        begin
            width_eff = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_W'(bbfe_pkg::MAX_WIDTH))
        begin
            width_eff = WIDTH_W'(bbfe_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = width_reg;
        end
    end

    assign row_wrap = (WIDTH_W'(col_pos_reg) + WIDTH_W'(1)) >= width_eff;
    assign col_step = row_wrap ? '0 : col_pos_reg + COL_W'(1);

    // neighborhood: outside the image counts as background
    assign cur = pix_in.pixel > thr_reg;
    assign up  = (row_pos_reg != '0) && up_raw;
    assign lf  = (col_pos_reg != '0) && left_bit_reg;
    assign ul  = (col_pos_reg != '0) && (row_pos_reg != '0) && upleft_bit_reg;

    assign convex_hit  = cur && !lf && !up && !ul;
    assign concave_hit = cur && lf && up && !ul;

    // saturating adders
    assign count_sum   = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign row_sum_sum = {1'b0, row_sum_reg} + (SUM_W+1)'(row_pos_reg);
    assign col_sum_sum = {1'b0, col_sum_reg} + (SUM_W+1)'(col_pos_reg);
    assign convex_sum  = {1'b0, convex_reg} + (QUAD_W+1)'(1);
    assign concave_sum = {1'b0, concave_reg} + (QUAD_W+1)'(1);

    // line buffer: write this column, prefetch the next item's column
    always_comb
    begin
        lb_req.wr_en   = acc;
        lb_req.wr_addr = col_pos_reg;
        lb_req.wr_bit  = cur;
        lb_req.rd_addr = acc ? col_pos_next : col_pos_reg;
    end

    bbfe_line_buf u_line_buf (
        .clk    (clk),
        .req    (lb_req),
        .up_bit (up_raw)
    );

    // accumulator update for the item at hand
    always_comb
    begin
        min_row_next = min_row_reg;
        min_col_next = min_col_reg;
        max_row_next = max_row_reg;
        max_col_next = max_col_reg;
        count_next   = count_reg;
        row_sum_next = row_sum_reg;
        col_sum_next = col_sum_reg;
        convex_next  = convex_reg;
        concave_next = concave_reg;

        if (convex_hit)
        begin
            convex_next = convex_sum[QUAD_W] ? '1 : convex_sum[QUAD_W-1:0];
        end
        if (concave_hit)
        begin
            concave_next = concave_sum[QUAD_W] ? '1 : concave_sum[QUAD_W-1:0];
        end
        if (cur)
        begin
            if (row_pos_reg < min_row_reg) min_row_next = row_pos_reg;
            if (row_pos_reg > max_row_reg) max_row_next = row_pos_reg;
            if (col_pos_reg < min_col_reg) min_col_next = col_pos_reg;
            if (col_pos_reg > max_col_reg) max_col_next = col_pos_reg;
            count_next   = count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];
            row_sum_next = row_sum_sum[SUM_W] ? '1 : row_sum_sum[SUM_W-1:0];
            col_sum_next = col_sum_sum[SUM_W] ? '1 : col_sum_sum[SUM_W-1:0];
        end
    end

    // scan position; frame end restarts at the origin
    always_comb
    begin
        if (last)
        begin
            col_pos_next    = '0;
            row_pos_next    = '0;
            left_bit_next   = 1'b0;
            upleft_bit_next = 1'b0;
        end
        else if (row_wrap)
        begin
            col_pos_next    = '0;
            row_pos_next    = (row_pos_reg != ROW_W'(bbfe_pkg::MAX_HEIGHT - 1))
                              ? row_pos_reg + ROW_W'(1) : row_pos_reg;
            left_bit_next   = 1'b0;
            upleft_bit_next = 1'b0;
        end
        else
        begin
            col_pos_next    = col_step;
            row_pos_next    = row_pos_reg;
            left_bit_next   = cur;
            upleft_bit_next = up;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            left_bit_reg   <= 1'b0;
            upleft_bit_reg <= 1'b0;
            min_row_reg    <= '1;
            min_col_reg    <= '1;
            max_row_reg    <= '0;
            max_col_reg    <= '0;
            count_reg      <= '0;
            row_sum_reg    <= '0;
            col_sum_reg    <= '0;
            convex_reg     <= '0;
            concave_reg    <= '0;
        end
        else if (acc)
        begin
            col_pos_reg    <= col_pos_next;
            row_pos_reg    <= row_pos_next;
            left_bit_reg   <= left_bit_next;
            upleft_bit_reg <= upleft_bit_next;
            if (last)
            begin
                min_row_reg <= '1;
                min_col_reg <= '1;
                max_row_reg <= '0;
                max_col_reg <= '0;
                count_reg   <= '0;
                row_sum_reg <= '0;
                col_sum_reg <= '0;
                convex_reg  <= '0;
                concave_reg <= '0;
            end
            else
            begin
                min_row_reg <= min_row_next;
                min_col_reg <= min_col_next;
                max_row_reg <= max_row_next;
                max_col_reg <= max_col_next;
                count_reg   <= count_next;
                row_sum_reg <= row_sum_next;
                col_sum_reg <= col_sum_next;
                convex_reg  <= convex_next;
                concave_reg <= concave_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result path: staging -> output register
    // ------------------------------------------------------------------
    assign o_free  = !o_valid_reg || feat_out.ready;
    assign s_move  = s_valid_reg && o_free;
    assign s_empty = (s_count_reg == '0);

    always_comb
    begin
        s_valid_next = s_valid_reg;
        if (acc && last)
        begin
            s_valid_next = 1'b1;
        end
        else if (s_move)
        begin
            s_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (s_move)
        begin
            o_valid_next = 1'b1;
        end
        else if (feat_out.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && last)
        begin
            s_min_row_reg <= min_row_next;
            s_min_col_reg <= min_col_next;
            s_max_row_reg <= max_row_next;
            s_max_col_reg <= max_col_next;
            s_count_reg   <= count_next;
            s_row_sum_reg <= row_sum_next;
            s_col_sum_reg <= col_sum_next;
            s_convex_reg  <= convex_next;
            s_concave_reg <= concave_next;
        end
    end

    // box fields read zero on an empty frame
    always_ff @(posedge clk)
    begin
        if (s_move)
        begin
            o_top_reg     <= s_empty ? '0 : BOX_W'(s_min_row_reg);
            o_left_reg    <= s_empty ? '0 : BOX_W'(s_min_col_reg);
            o_bottom_reg  <= s_empty ? '0 : BOX_W'(s_max_row_reg);
            o_right_reg   <= s_empty ? '0 : BOX_W'(s_max_col_reg);
            o_count_reg   <= s_count_reg;
            o_row_sum_reg <= s_row_sum_reg;
            o_col_sum_reg <= s_col_sum_reg;
            o_euler_reg   <= EULER_W'(s_convex_reg) - EULER_W'(s_concave_reg);
            o_empty_reg   <= s_empty;
        end
    end

    assign feat_out.valid        = o_valid_reg;
    assign feat_out.top_row      = o_top_reg;
    assign feat_out.left_col     = o_left_reg;
    assign feat_out.bottom_row   = o_bottom_reg;
    assign feat_out.right_col    = o_right_reg;
    assign feat_out.fg_count     = o_count_reg;
    assign feat_out.row_total    = o_row_sum_reg;
    assign feat_out.col_total    = o_col_sum_reg;
    assign feat_out.euler_number = $signed(o_euler_reg);
    assign feat_out.empty_frame  = o_empty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BBFE_ASSERT_NEXT(a_last_staged, acc && last, s_valid_reg,
        "frame end item did not reach the staging register")
    `BBFE_ASSERT_NEXT(a_last_rewind, acc && last,
        (col_pos_reg == '0) && (row_pos_reg == '0) && (count_reg == '0),
        "scan position or totals not cleared after frame end")
    `BBFE_ASSERT_NOW(a_box_order, count_reg != '0,
        (min_row_reg <= max_row_reg) && (min_col_reg <= max_col_reg),
        "bounding box inverted with foreground present")
    `BBFE_ASSERT_NOW(a_empty_zero, feat_out.valid && feat_out.empty_frame,
        (feat_out.fg_count == '0) && (feat_out.top_row == '0) && (feat_out.right_col == '0),
        "empty frame result carries nonzero fields")

endmodule

`default_nettype wire
